// ===== hdl/mevs_pkg.sv =====
// Shared constants, types and controller/datapath interface structs for the
// mesh edge and vertex store. No dependencies.
`default_nettype none

package mevs_pkg;

	// Table capacities and the number of coordinate bits that are compared.
	localparam int VERTEX_CAPACITY = 256;
	localparam int EDGE_CAPACITY   = 512;
	localparam int COORD_BITS      = 16;

	// Fixed field widths of the item and result interfaces.
	localparam int IN_COORD_W    = 16;
	localparam int TAG_W         = 11;
	localparam int STATUS_W      = 2;
	localparam int EDGE_SLOT_W   = 9;
	localparam int VERTEX_SLOT_W = 8;

	// Derived widths.
	localparam int CMP_W   = (COORD_BITS < IN_COORD_W) ? COORD_BITS : IN_COORD_W;
	localparam int VADDR_W = $clog2(VERTEX_CAPACITY);
	localparam int VCNT_W  = $clog2(VERTEX_CAPACITY + 1);
	localparam int EADDR_W = $clog2(EDGE_CAPACITY);
	localparam int ECNT_W  = $clog2(EDGE_CAPACITY + 1);
	localparam int SCAN_W  = (VCNT_W > ECNT_W) ? VCNT_W : ECNT_W;

	typedef logic signed [IN_COORD_W-1:0] in_coord_t;
	typedef logic signed [TAG_W-1:0]      in_tag_t;
	typedef logic [TAG_W-1:0]             tag_t;
	typedef logic [CMP_W-1:0]             cmp_t;
	typedef logic [STATUS_W-1:0]          status_t;

	// Result status codes.
	localparam status_t ST_NEW   = 2'd0;
	localparam status_t ST_EXIST = 2'd1;
	localparam status_t ST_DEGEN = 2'd2;
	localparam status_t ST_FULL  = 2'd3;

	// Contour tag pattern that marks an inner edge.
	localparam tag_t INNER_TAG = {TAG_W{1'b1}};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_clear;
		logic vscan;
		logic escan;
		logic res_degen;
		logic res_full;
		logic add_va;
		logic add_vb;
		logic edge_write;
		logic publish;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic degen;
		logic vscan_done;
		logic escan_done;
		logic va_found;
		logic vb_found;
		logic e_found;
		logic vfull;
		logic efull;
		logic res_free;
		logic tables_ok;
	} sts_t;

endpackage

`default_nettype wire

// ===== hdl/mevs_ctrl.sv =====
// Sequencing state machine for the mesh edge and vertex store.
// Depends on mevs_pkg for the command and status structs.
`default_nettype none

module mevs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  mevs_pkg::sts_t sts,
	output mevs_pkg::cmd_t cmd,
	output logic           in_stall
);
	import mevs_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHECK = 4'd1;
	localparam logic [3:0] S_VSCAN = 4'd2;
	localparam logic [3:0] S_VDEC  = 4'd3;
	localparam logic [3:0] S_ESCAN = 4'd4;
	localparam logic [3:0] S_EDEC  = 4'd5;
	localparam logic [3:0] S_ADDV  = 4'd6;
	localparam logic [3:0] S_EWR   = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// The block takes a new item only between items.
	assign in_stall = (state_q != S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.degen) begin
					cmd.res_degen = 1'b1;
					state_d       = S_OUT;
				end else begin
					cmd.scan_clear = 1'b1;
					state_d        = S_VSCAN;
				end
			end
			S_VSCAN: begin
				cmd.vscan = 1'b1;
				if (sts.vscan_done) begin
					state_d = S_VDEC;
				end
			end
			S_VDEC: begin
				if (sts.va_found && sts.vb_found) begin
					cmd.scan_clear = 1'b1;
					state_d        = S_ESCAN;
				end else if (sts.vfull || sts.efull) begin
					cmd.res_full = 1'b1;
					state_d      = S_OUT;
				end else begin
					state_d = S_ADDV;
				end
			end
			S_ESCAN: begin
				cmd.escan = 1'b1;
				if (sts.escan_done) begin
					state_d = S_EDEC;
				end
			end
			S_EDEC: begin
				if (!sts.e_found && sts.efull) begin
					cmd.res_full = 1'b1;
					state_d      = S_OUT;
				end else begin
					state_d = S_EWR;
				end
			end
			S_ADDV: begin
				if (!sts.va_found) begin
					cmd.add_va = 1'b1;
				end else if (!sts.vb_found) begin
					cmd.add_vb = 1'b1;
				end else begin
					state_d = S_EWR;
				end
			end
			S_EWR: begin
				cmd.edge_write = 1'b1;
				state_d        = S_OUT;
			end
			S_OUT: begin
				if (sts.res_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/mevs_datapath.sv =====
// Datapath of the mesh edge and vertex store: vertex and edge memories, scan
// counter, match flags, pending result and output register. Uses mevs_pkg.
`default_nettype none

module mevs_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mevs_pkg::in_coord_t                 start_x,
	input  mevs_pkg::in_coord_t                 start_y,
	input  mevs_pkg::in_coord_t                 end_x,
	input  mevs_pkg::in_coord_t                 end_y,
	input  mevs_pkg::in_tag_t                   contour_tag,
	input  mevs_pkg::cmd_t                      cmd,
	input  logic                                out_stall,
	output mevs_pkg::sts_t                      sts,
	output logic                                out_valid,
	output mevs_pkg::status_t                   status,
	output logic [mevs_pkg::EDGE_SLOT_W-1:0]    edge_slot,
	output logic [mevs_pkg::VERTEX_SLOT_W-1:0]  first_vertex_slot,
	output logic [mevs_pkg::VERTEX_SLOT_W-1:0]  second_vertex_slot
);
	import mevs_pkg::*;

	localparam int VW = 2 * CMP_W;
	localparam int EW = 2 * VADDR_W + TAG_W;

	// Memories and their registered read data.
	logic [VW-1:0] vmem [VERTEX_CAPACITY];
	logic [EW-1:0] emem [EDGE_CAPACITY];
	logic [VW-1:0] vrd_s1;
	logic [EW-1:0] erd_s1;

	// Current item.
	cmp_t x0_q, y0_q, x1_q, y1_q;
	tag_t tag_q;

	// Counters and scan control.
	logic [VCNT_W-1:0] vcount_q;
	logic [ECNT_W-1:0] ecount_q;
	logic [SCAN_W-1:0] idx_q;
	logic [SCAN_W-1:0] rd_idx_s1;
	logic              rd_vld_s1;

	// Match results.
	logic               va_found_q, vb_found_q, e_found_q;
	logic [VADDR_W-1:0] va_q, vb_q, ep_q, eq_q;
	logic [EADDR_W-1:0] e_q;
	tag_t               econt_q;

	// Pending result and output register.
	status_t                  pst_q;
	logic [EDGE_SLOT_W-1:0]   pedge_q;
	logic [VERTEX_SLOT_W-1:0] pfv_q, psv_q;
	logic                     out_vld_q;
	status_t                  ost_q;
	logic [EDGE_SLOT_W-1:0]   oedge_q;
	logic [VERTEX_SLOT_W-1:0] ofv_q, osv_q;

	logic               v_more, e_more, v_issue, e_issue;
	logic               vhit_a, vhit_b, ehit;
	cmp_t               vrd_x, vrd_y;
	logic [VADDR_W-1:0] erd_p, erd_q;
	tag_t               erd_c;
	logic               vwe, ewe;
	logic [VADDR_W-1:0] vwaddr;
	logic [EADDR_W-1:0] ewaddr;
	logic [VW-1:0]      vwdata;
	logic [EW-1:0]      ewdata;
	logic [VCNT_W:0]    vneed_sum;

	// Scan progress: one table entry is read per cycle.
	assign v_more  = (idx_q < SCAN_W'(vcount_q)) && !(va_found_q && vb_found_q);
	assign e_more  = (idx_q < SCAN_W'(ecount_q)) && !e_found_q;
	assign v_issue = cmd.vscan && v_more;
	assign e_issue = cmd.escan && e_more;

	// Compare the entry read in the previous cycle.
	assign {vrd_x, vrd_y}        = vrd_s1;
	assign {erd_p, erd_q, erd_c} = erd_s1;
	assign vhit_a = cmd.vscan && rd_vld_s1 && !va_found_q && (vrd_x == x0_q) && (vrd_y == y0_q);
	assign vhit_b = cmd.vscan && rd_vld_s1 && !vb_found_q && (vrd_x == x1_q) && (vrd_y == y1_q);
	assign ehit   = cmd.escan && rd_vld_s1 && !e_found_q &&
		(((erd_p == va_q) && (erd_q == vb_q)) || ((erd_p == vb_q) && (erd_q == va_q)));

	// Table writes.
	assign vwe    = (cmd.add_va && !va_found_q) || (cmd.add_vb && !vb_found_q);
	assign vwaddr = vcount_q[VADDR_W-1:0];
	assign vwdata = cmd.add_va ? {x0_q, y0_q} : {x1_q, y1_q};
	assign ewe    = cmd.edge_write && (!e_found_q || (econt_q == INNER_TAG));
	assign ewaddr = e_found_q ? e_q : ecount_q[EADDR_W-1:0];
	assign ewdata = e_found_q ? {ep_q, eq_q, tag_q} : {va_q, vb_q, tag_q};

	// Vertices still needed against the capacity.
	assign vneed_sum = {1'b0, vcount_q} + (VCNT_W + 1)'(!va_found_q)
		+ (VCNT_W + 1)'(!vb_found_q);

	// Status to the controller.
	always_comb begin
		sts            = '0;
		sts.degen      = (x0_q == x1_q) && (y0_q == y1_q);
		sts.vscan_done = !rd_vld_s1 && !v_more;
		sts.escan_done = !rd_vld_s1 && !e_more;
		sts.va_found   = va_found_q;
		sts.vb_found   = vb_found_q;
		sts.e_found    = e_found_q;
		sts.vfull      = vneed_sum > (VCNT_W + 1)'(VERTEX_CAPACITY);
		sts.efull      = ecount_q >= ECNT_W'(EDGE_CAPACITY);
		sts.res_free   = !out_vld_q || !out_stall;
		sts.tables_ok  = (vcount_q <= VCNT_W'(VERTEX_CAPACITY)) &&
			(ecount_q <= ECNT_W'(EDGE_CAPACITY));
	end

	// Vertex memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[vwaddr] <= vwdata;
		end
		vrd_s1 <= vmem[idx_q[VADDR_W-1:0]];
	end

	// Edge memory: endpoints and contour tag in one word.
	always_ff @(posedge clk) begin
		if (ewe) begin
			emem[ewaddr] <= ewdata;
		end
		erd_s1 <= emem[idx_q[EADDR_W-1:0]];
	end

	// Control state: counters, scan index, flags and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q   <= '0;
			ecount_q   <= '0;
			idx_q      <= '0;
			rd_vld_s1  <= 1'b0;
			va_found_q <= 1'b0;
			vb_found_q <= 1'b0;
			e_found_q  <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			rd_vld_s1 <= v_issue || e_issue;
			if (v_issue || e_issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.load) begin
				va_found_q <= 1'b0;
				vb_found_q <= 1'b0;
			end
			if (cmd.scan_clear) begin
				idx_q     <= '0;
				e_found_q <= 1'b0;
			end
			if (vhit_a || cmd.add_va) begin
				va_found_q <= 1'b1;
			end
			if (vhit_b || cmd.add_vb) begin
				vb_found_q <= 1'b1;
			end
			if (ehit) begin
				e_found_q <= 1'b1;
			end
			if (vwe) begin
				vcount_q <= vcount_q + 1'b1;
			end
			if (cmd.edge_write && !e_found_q) begin
				ecount_q <= ecount_q + 1'b1;
			end
			if (cmd.publish) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (cmd.load) begin
			x0_q  <= start_x[CMP_W-1:0];
			y0_q  <= start_y[CMP_W-1:0];
			x1_q  <= end_x[CMP_W-1:0];
			y1_q  <= end_y[CMP_W-1:0];
			tag_q <= tag_t'(contour_tag);
		end
		if (vhit_a) begin
			va_q <= rd_idx_s1[VADDR_W-1:0];
		end
		if (vhit_b) begin
			vb_q <= rd_idx_s1[VADDR_W-1:0];
		end
		if (cmd.add_va && !va_found_q) begin
			va_q <= vwaddr;
		end
		if (cmd.add_vb && !vb_found_q) begin
			vb_q <= vwaddr;
		end
		if (ehit) begin
			e_q     <= rd_idx_s1[EADDR_W-1:0];
			ep_q    <= erd_p;
			eq_q    <= erd_q;
			econt_q <= erd_c;
		end
		// Pending result of the current item.
		if (cmd.res_degen || cmd.res_full) begin
			pst_q   <= cmd.res_degen ? ST_DEGEN : ST_FULL;
			pedge_q <= '0;
			pfv_q   <= '0;
			psv_q   <= '0;
		end
		if (cmd.edge_write) begin
			pst_q   <= e_found_q ? ST_EXIST : ST_NEW;
			pedge_q <= EDGE_SLOT_W'(ewaddr);
			pfv_q   <= VERTEX_SLOT_W'(va_q);
			psv_q   <= VERTEX_SLOT_W'(vb_q);
		end
		if (cmd.publish) begin
			ost_q   <= pst_q;
			oedge_q <= pedge_q;
			ofv_q   <= pfv_q;
			osv_q   <= psv_q;
		end
	end

	assign out_valid          = out_vld_q;
	assign status             = ost_q;
	assign edge_slot          = oedge_q;
	assign first_vertex_slot  = ofv_q;
	assign second_vertex_slot = osv_q;

endmodule

`default_nettype wire

// ===== hdl/mesh_edge_vertex_store_top.sv =====
// Top level of the mesh edge and vertex store: controller and datapath.
// Depends on mevs_pkg, mevs_ctrl and mevs_datapath.
//
//  Channel  Handshake             Fields
//  -------  --------------------  ---------------------------------------------
//  in       in_valid / in_stall   start_x, start_y, end_x, end_y, contour_tag
//  out      out_valid / out_stall status, edge_slot, first_vertex_slot,
//                                 second_vertex_slot
//
// The time per item is set by the vertex scan and the edge scan, which each
// read one table entry per cycle through that table's single read port.
// Degenerate items skip both scans. Reset clears the two counts and the
// control flags but not the table memories; no clearing pass runs. A new item
// is taken while the previous result waits under out_stall; the next result
// waits until the output register is free.
`default_nettype none

module mesh_edge_vertex_store_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  mevs_pkg::in_coord_t                 start_x,
	input  mevs_pkg::in_coord_t                 start_y,
	input  mevs_pkg::in_coord_t                 end_x,
	input  mevs_pkg::in_coord_t                 end_y,
	input  mevs_pkg::in_tag_t                   contour_tag,
	output logic                                out_valid,
	input  logic                                out_stall,
	output mevs_pkg::status_t                   status,
	output logic [mevs_pkg::EDGE_SLOT_W-1:0]    edge_slot,
	output logic [mevs_pkg::VERTEX_SLOT_W-1:0]  first_vertex_slot,
	output logic [mevs_pkg::VERTEX_SLOT_W-1:0]  second_vertex_slot
);
	import mevs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	mevs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// Tables, scan logic and result registers.
	mevs_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.start_x            (start_x),
		.start_y            (start_y),
		.end_x              (end_x),
		.end_y              (end_y),
		.contour_tag        (contour_tag),
		.cmd                (cmd),
		.out_stall          (out_stall),
		.sts                (sts),
		.out_valid          (out_valid),
		.status             (status),
		.edge_slot          (edge_slot),
		.first_vertex_slot  (first_vertex_slot),
		.second_vertex_slot (second_vertex_slot)
	);

	// An accepted item holds off the next one: in_stall is high in the cycle after it.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after an item was accepted");

	// A result is only moved into a free output register.
	a_publish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> (!out_valid || !out_stall))
		else $error("result published over an untaken result");

	// The counts never pass the table capacities.
	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		sts.tables_ok)
		else $error("table count exceeds capacity");

	// A new result appears only after the controller publishes one.
	a_valid_from_publish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.publish))
		else $error("output valid rose without a publish");

endmodule

`default_nettype wire
